// File: design/cms_pkg.sv
// ============================================================================
// cms_pkg: shared types and constants of the count-min sketch
// Field widths, hash constants, register indexes, the controller state type
// and the control word that the sequencer broadcasts to the counter cells.
// ============================================================================
package cms_pkg;

  localparam int MaxRows  = 4;
  localparam int Rows     = 4;
  localparam int Columns  = 1024;

  localparam int CoefW    = 17;
  localparam int KeyW     = 31;
  localparam int WordW    = 32;
  localparam int HashW    = 48;
  localparam int ModW     = 17;
  localparam int CfgIdxW  = 4;

  localparam int SplitHi   = 32;
  localparam int Fold1W    = 33;
  localparam int Fold2W    = 31;
  localparam int QuotW     = 15;
  localparam int RecipW    = 32;
  localparam int HashSteps = 8;

  localparam logic [ModW-1:0]         HashPrime = 17'd99991;
  localparam logic signed [WordW-1:0] QueryCap  = 32'sd1000000000;

  localparam logic [ModW-1:0]   PowSplitMod = ModW'((64'd1 << SplitHi) % 64'(HashPrime));
  localparam logic [ModW-1:0]   PowModMod   = ModW'((64'd1 << ModW) % 64'(HashPrime));
  localparam logic [RecipW-1:0] HashRecip   = RecipW'((64'd1 << HashW) / 64'(HashPrime));

  localparam logic [CoefW-1:0] MultReset   [MaxRows] = '{17'd1, 17'd3, 17'd5, 17'd9};
  localparam logic [CoefW-1:0] OffsetReset [MaxRows] = '{17'd1, 17'd7, 17'd11, 17'd13};

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_MULT   = 4'd0,
    REG_ROW0_OFFSET = 4'd1,
    REG_ROW1_MULT   = 4'd2,
    REG_ROW1_OFFSET = 4'd3,
    REG_ROW2_MULT   = 4'd4,
    REG_ROW2_OFFSET = 4'd5,
    REG_ROW3_MULT   = 4'd6,
    REG_ROW3_OFFSET = 4'd7
  } cms_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_HASH,
    ST_READ,
    ST_WRITE,
    ST_MIN,
    ST_OUT
  } cms_state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic hash_step;
    logic rd;
    logic wr;
    logic min_step;
  } cms_ctl_t;

endpackage

// File: design/cms_if.sv
// ============================================================================
// cms_item_if / cms_result_if: valid-ready channels of the sketch
// One interface carries the request transactions, the other the estimates.
// ============================================================================
interface cms_item_if;
  import cms_pkg::*;

  logic            valid;
  logic            ready;
  logic            mode;
  logic [KeyW-1:0] item_key;
  logic signed [WordW-1:0] amount;

  modport source (output valid, output mode, output item_key, output amount, input ready);
  modport sink (input valid, input mode, input item_key, input amount, output ready);
endinterface

interface cms_result_if;
  import cms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink (input valid, input estimate, output ready);
endinterface

// File: design/cms_ctrl.sv
// ============================================================================
// cms_ctrl: sequencer of the sketch
// Runs the clearing pass, steps the cells through hashing, bank access and
// the minimum chain, and hands finished estimates to the output register.
// ============================================================================
module cms_ctrl #(
  parameter int ROWS    = cms_pkg::Rows,
  parameter int COLUMNS = cms_pkg::Columns,
  parameter int IDX_W   = $clog2(COLUMNS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_ready,
  input  logic                 out_busy,
  output logic                 out_load,
  output cms_pkg::cms_ctl_t    ctl,
  output logic [IDX_W-1:0]     clr_addr
);
  import cms_pkg::*;

  localparam int CNT_W = $clog2(COLUMNS > HashSteps ? COLUMNS : HashSteps);

  cms_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             query, query_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      query <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      query <= query_next;
    end
  end

  assign clr_addr = cnt[IDX_W-1:0];

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    query_next = query;
    ctl        = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (cnt == CNT_W'(COLUMNS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          query_next = in_mode;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.load   = 1'b1;
        state_next = ST_HASH;
      end
      ST_HASH: begin
        ctl.hash_step = 1'b1;
        if (cnt == CNT_W'(HashSteps - 1)) begin
          cnt_next   = '0;
          state_next = ST_READ;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_READ: begin
        ctl.rd     = 1'b1;
        state_next = query ? ST_MIN : ST_WRITE;
      end
      ST_WRITE: begin
        ctl.wr     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MIN: begin
        ctl.min_step = 1'b1;
        if (cnt == CNT_W'(ROWS - 1)) begin
          cnt_next   = '0;
          state_next = ST_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

// File: design/cms_cell.sv
// ============================================================================
// cms_cell: one counter row of the sketch
// Hashes the key with its own coefficients by folding and reciprocal
// multiplication, owns the row's counter bank, and folds its counter into the
// running minimum that travels from the previous cell to the next.
// ============================================================================
module cms_cell #(
  parameter int COLUMNS = cms_pkg::Columns,
  parameter int IDX_W   = $clog2(COLUMNS)
) (
  input  logic                                  clk,
  input  cms_pkg::cms_ctl_t                     ctl,
  input  logic [IDX_W-1:0]                      clr_addr,
  input  logic [cms_pkg::CoefW-1:0]             mult,
  input  logic [cms_pkg::CoefW-1:0]             offset,
  input  logic [cms_pkg::KeyW-1:0]              item_key,
  input  logic signed [cms_pkg::WordW-1:0]      amount,
  input  logic signed [cms_pkg::WordW-1:0]      min_in,
  output logic signed [cms_pkg::WordW-1:0]      min_out
);
  import cms_pkg::*;

  localparam int ColShift  = ModW + IDX_W;
  localparam int ColRecipW = ModW + 1;
  localparam int ColW      = IDX_W + 1;
  localparam logic [ColRecipW-1:0] ColRecip = ColRecipW'((64'd1 << ColShift) / 64'(COLUMNS));
  localparam logic [ColW-1:0]      ColCount = ColW'(COLUMNS);

  logic [HashW-1:0]                hash_in;
  logic [HashW-1:0]                prod;
  logic [Fold1W-1:0]               fold_hi;
  logic [Fold2W-1:0]               fold_lo;
  logic [Fold2W+RecipW-1:0]        quot_prod;
  logic [QuotW-1:0]                quot;
  logic [Fold2W-1:0]               quot_src;
  logic [ModW:0]                   rem_raw;
  logic [ModW-1:0]                 hash_val;
  logic [ModW+ColRecipW-1:0]       col_prod;
  logic [ModW-1:0]                 col_quot;
  logic [ModW-1:0]                 col_src;
  logic [ColW-1:0]                 col_raw;
  logic [IDX_W-1:0]                idx;
  logic [IDX_W-1:0]                waddr;
  logic signed [WordW-1:0]         wdata;
  logic signed [WordW:0]           sum;
  logic signed [WordW-1:0]         rdata;
  logic signed [WordW-1:0]         mem [COLUMNS];

  assign prod      = HashW'(mult) * HashW'(item_key);
  assign quot_prod = (Fold2W+RecipW)'(fold_lo) * (Fold2W+RecipW)'(HashRecip);
  assign col_prod  = (ModW+ColRecipW)'(hash_val) * (ModW+ColRecipW)'(ColRecip);

  // Each step advances every stage, so the column index is final after
  // HashSteps steps: two folds, the quotient estimate, its remainder, its
  // correction, the column quotient estimate, its remainder and the last correction.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hash_in <= prod + HashW'(offset);
    end
    if (ctl.hash_step) begin
      fold_hi  <= Fold1W'(hash_in[HashW-1:SplitHi]) * Fold1W'(PowSplitMod)
                  + Fold1W'(hash_in[SplitHi-1:0]);
      fold_lo  <= Fold2W'(fold_hi[Fold1W-1:ModW]) * Fold2W'(PowModMod)
                  + Fold2W'(fold_hi[ModW-1:0]);
      quot     <= QuotW'(quot_prod >> HashW);
      quot_src <= fold_lo;
      rem_raw  <= (ModW+1)'(quot_src - Fold2W'(quot) * Fold2W'(HashPrime));
      hash_val <= (rem_raw >= {1'b0, HashPrime}) ? ModW'(rem_raw - {1'b0, HashPrime})
                                                 : ModW'(rem_raw);
      col_quot <= ModW'(col_prod >> ColShift);
      col_src  <= hash_val;
      col_raw  <= ColW'(col_src - col_quot * ModW'(COLUMNS));
      idx      <= (col_raw >= ColCount) ? IDX_W'(col_raw - ColCount) : IDX_W'(col_raw);
    end
  end

  // Counter update saturates at the signed 32-bit limits.
  assign sum = {rdata[WordW-1], rdata} + {amount[WordW-1], amount};

  always_comb begin
    if (ctl.clr) begin
      waddr = clr_addr;
      wdata = '0;
    end else begin
      waddr = idx;
      if (sum[WordW] != sum[WordW-1]) begin
        wdata = sum[WordW] ? {1'b1, {(WordW - 1){1'b0}}} : {1'b0, {(WordW - 1){1'b1}}};
      end else begin
        wdata = sum[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr || ctl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.min_step) begin
      min_out <= (rdata < min_in) ? rdata : min_in;
    end
  end

endmodule

// File: design/count_min_sketch.sv
// Count-min sketch, one transaction at a time through a chain of row cells.
// Each transaction is loaded, passes the hash reduction steps and takes one bank read.
// An add then writes its banks, and the sequencer returns to idle to take the next one.
// A query runs the minimum chain and loads its estimate into the output register; the next
// transaction is taken as it turns valid, or once a stalled estimate has left the register.
// After reset the banks clear column by column with no input taken; config resets to defaults.
// ============================================================================
// count_min_sketch: top level of the count-min sketch
// Holds the hash coefficients, the transaction payload and the output
// register, and connects the sequencer to the row of counter cells.
// ============================================================================
module count_min_sketch #(
  parameter int ROWS    = cms_pkg::Rows,
  parameter int COLUMNS = cms_pkg::Columns
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cms_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cms_pkg::CoefW-1:0]     cfg_data,
  cms_item_if.sink                      item,
  cms_result_if.source                  result
);
  import cms_pkg::*;

  localparam int IDX_W = $clog2(COLUMNS);

  logic [CoefW-1:0]        mult   [MaxRows];
  logic [CoefW-1:0]        offset [MaxRows];
  logic [KeyW-1:0]         key_q;
  logic signed [WordW-1:0] amount_q;
  logic                    out_valid;
  logic signed [WordW-1:0] estimate;
  logic                    out_busy;
  logic                    out_load;
  logic                    in_ready;
  cms_ctl_t                ctl;
  logic [IDX_W-1:0]        clr_addr;
  logic signed [WordW-1:0] min_chain [ROWS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mult   <= MultReset;
      offset <= OffsetReset;
    end else if (cfg_we) begin
      case (cms_reg_t'(cfg_index))
        REG_ROW0_MULT:   mult[0]   <= cfg_data;
        REG_ROW0_OFFSET: offset[0] <= cfg_data;
        REG_ROW1_MULT:   mult[1]   <= cfg_data;
        REG_ROW1_OFFSET: offset[1] <= cfg_data;
        REG_ROW2_MULT:   mult[2]   <= cfg_data;
        REG_ROW2_OFFSET: offset[2] <= cfg_data;
        REG_ROW3_MULT:   mult[3]   <= cfg_data;
        REG_ROW3_OFFSET: offset[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item.ready = in_ready;

  always_ff @(posedge clk) begin
    if (item.valid && in_ready) begin
      key_q    <= item.item_key;
      amount_q <= item.amount;
    end
  end

  cms_ctrl #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .out_load (out_load),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  assign min_chain[0] = QueryCap;

  for (genvar r = 0; r < ROWS; r++) begin : g_cell
    cms_cell #(
      .COLUMNS (COLUMNS),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .clr_addr (clr_addr),
      .mult     (mult[r]),
      .offset   (offset[r]),
      .item_key (key_q),
      .amount   (amount_q),
      .min_in   (min_chain[r]),
      .min_out  (min_chain[r+1])
    );
  end

  assign out_busy = out_valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      estimate <= min_chain[ROWS];
    end
  end

  assign result.valid    = out_valid;
  assign result.estimate = estimate;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item.ready)
    else $error("input accepted during the clearing pass");

  a_estimate_capped: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.estimate <= QueryCap))
    else $error("estimate above the query cap");

  a_idle_cells_quiet: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !(ctl.hash_step || ctl.wr || ctl.clr || ctl.min_step))
    else $error("cells active while a new transaction can be taken");

endmodule

// File: bench/count_min_sketch_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// count_min_sketch_tb: regression bench for the count-min sketch
// Sends add and query transactions through the request channel, keeps its own
// copy of the counter rows and hash coefficients, and checks every estimate
// against that copy. Coefficients are reprogrammed between phases while the
// block is idle, and both channels idle and stall at random.
// ============================================================================
module count_min_sketch_tb;
  import cms_pkg::*;

  localparam int    AddBusyCycles = 80;
  localparam int    CycleLimit    = 600000;
  localparam int    PoolSize      = 12;
  localparam int    NumRegs       = 8;
  localparam logic  ModeAdd       = 1'b0;
  localparam logic  ModeQuery     = 1'b1;
  localparam logic [CoefW-1:0] CoefHigh = 17'd99992;
  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam logic signed [WordW-1:0] AmountMax = 32'sh7fffffff;
  localparam logic signed [WordW-1:0] AmountMin = 32'sh80000000;
  localparam logic [KeyW-1:0] KeyMax = '1;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CoefW-1:0]    cfg_data;

  cms_item_if   item_ch ();
  cms_result_if result_ch ();

  count_min_sketch i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  logic [CoefW-1:0]        coef_mult   [MaxRows];
  logic [CoefW-1:0]        coef_offset [MaxRows];
  logic signed [WordW-1:0] tally [Rows][Columns];
  logic signed [WordW-1:0] estimate_queue [$];
  logic signed [WordW-1:0] est_expected;
  logic [KeyW-1:0]         key_pool [PoolSize];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int stall_left     = 0;
  int stall_level    = 0;
  int gap_max        = 4;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned column_of(input int row, input logic [KeyW-1:0] key);
    logic [63:0] h;
    h = {47'd0, coef_mult[row]} * {33'd0, key} + {47'd0, coef_offset[row]};
    h = h % {47'd0, HashPrime};
    return int'(h % 64'(Columns));
  endfunction

  function automatic void predict_request(input logic m, input logic [KeyW-1:0] key,
                                          input logic signed [WordW-1:0] amt);
    longint sum;
    longint best;
    int unsigned c;
    if (m == ModeAdd) begin
      for (int r = 0; r < Rows; r++) begin
        c = column_of(r, key);
        sum = longint'(tally[r][c]) + longint'(amt);
        if (sum > WordMax) sum = WordMax;
        if (sum < WordMin) sum = WordMin;
        tally[r][c] = WordW'(sum);
      end
    end else begin
      best = longint'(QueryCap);
      for (int r = 0; r < Rows; r++) begin
        c = column_of(r, key);
        if (longint'(tally[r][c]) < best) best = longint'(tally[r][c]);
      end
      estimate_queue.insert(estimate_queue.size(), WordW'(best));
    end
  endfunction

  function automatic void model_write(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] d);
    case (idx)
      REG_ROW0_MULT:   coef_mult[0]   = d;
      REG_ROW0_OFFSET: coef_offset[0] = d;
      REG_ROW1_MULT:   coef_mult[1]   = d;
      REG_ROW1_OFFSET: coef_offset[1] = d;
      REG_ROW2_MULT:   coef_mult[2]   = d;
      REG_ROW2_OFFSET: coef_offset[2] = d;
      REG_ROW3_MULT:   coef_mult[3]   = d;
      REG_ROW3_OFFSET: coef_offset[3] = d;
      default: ;
    endcase
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    model_write(idx, d);
  endtask

  task automatic program_coefs(input logic [CoefW-1:0] m0, o0, m1, o1, m2, o2, m3, o3);
    write_reg(REG_ROW0_MULT, m0);
    write_reg(REG_ROW0_OFFSET, o0);
    write_reg(REG_ROW1_MULT, m1);
    write_reg(REG_ROW1_OFFSET, o1);
    write_reg(REG_ROW2_MULT, m2);
    write_reg(REG_ROW2_OFFSET, o2);
    write_reg(REG_ROW3_MULT, m3);
    write_reg(REG_ROW3_OFFSET, o3);
    write_reg(CfgIdxW'($urandom_range(NumRegs, (1 << CfgIdxW) - 1)),
              CoefW'($urandom_range(0, (1 << CoefW) - 1)));
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(input logic m, input logic [KeyW-1:0] key,
                              input logic signed [WordW-1:0] amt);
    if (burst_left == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    item_ch.valid    <= 1'b1;
    item_ch.mode     <= m;
    item_ch.item_key <= key;
    item_ch.amount   <= amt;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    predict_request(m, key, amt);
  endtask

  // The block may still be busy with an add after the last estimate arrives.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (estimate_queue.size() != 0) @(posedge clk);
    repeat (AddBusyCycles) @(posedge clk);
  endtask

  function automatic logic [CoefW-1:0] pick_coef(input bit extremes);
    if (!extremes) return CoefW'($urandom_range(1, CoefHigh));
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CoefW'(1);
      2:       return CoefHigh;
      3:       return '1;
      default: return CoefW'($urandom_range(0, (1 << CoefW) - 1));
    endcase
  endfunction

  function automatic logic signed [WordW-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return WordW'($urandom);
      1:       return $urandom_range(0, 1) ? AmountMax : AmountMin;
      2:       return WordW'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return WordW'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(ModeQuery, '0, '0);
    send_request(ModeQuery, KeyMax, AmountMax);
    send_request(ModeAdd, KeyW'(5), '0);
    send_request(ModeQuery, KeyW'(5), '0);
    wait_idle();
  endtask

  task automatic test_saturation();
    send_request(ModeAdd, '0, AmountMax);
    send_request(ModeQuery, '0, '0);
    send_request(ModeAdd, '0, AmountMax);
    send_request(ModeAdd, '0, WordW'(1));
    send_request(ModeQuery, '0, AmountMin);
    send_request(ModeAdd, KeyMax, AmountMin);
    send_request(ModeAdd, KeyMax, -32'sd1);
    send_request(ModeQuery, KeyMax, '0);
    send_request(ModeAdd, KeyMax, AmountMax);
    send_request(ModeQuery, KeyMax, '0);
    wait_idle();
  endtask

  task automatic test_coef_extremes();
    program_coefs('0, '0, '1, '1, CoefHigh, CoefW'(1), CoefW'(1), CoefHigh);
    send_request(ModeAdd, KeyW'(31'h2aaaaaaa), WordW'(7));
    send_request(ModeQuery, KeyW'(31'h2aaaaaaa), '0);
    send_request(ModeAdd, KeyW'(31'h55555555), -32'sd3);
    send_request(ModeQuery, KeyW'(31'h55555555), '0);
    send_request(ModeQuery, '0, '0);
    send_request(ModeQuery, KeyMax, '0);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n, input bit extremes, input int stalls,
                                     input int gaps);
    logic             m;
    logic [KeyW-1:0]  key;
    stall_level = stalls;
    gap_max     = gaps;
    program_coefs(pick_coef(extremes), pick_coef(extremes), pick_coef(extremes),
                  pick_coef(extremes), pick_coef(extremes), pick_coef(extremes),
                  pick_coef(extremes), pick_coef(extremes));
    for (int i = 0; i < PoolSize; i++)
      key_pool[i] = (i < 2) ? KeyW'(i) : KeyW'($urandom);
    for (int i = 0; i < n; i++) begin
      m   = ($urandom_range(0, 9) < 4) ? ModeQuery : ModeAdd;
      key = ($urandom_range(0, 4) == 0) ? KeyW'($urandom)
                                        : key_pool[$urandom_range(0, PoolSize - 1)];
      send_request(m, key, pick_amount());
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("count_min_sketch regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (estimate_queue.size() == 0) begin
          report_mismatch($sformatf("estimate %0d with no query pending",
                                    result_ch.estimate));
        end else begin
          est_expected = estimate_queue.pop_front();
          if (result_ch.estimate !== est_expected)
            report_mismatch($sformatf("estimate expected %0d, got %0d",
                                      est_expected, result_ch.estimate));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_level != 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, (stall_level == 1) ? 6 : 60);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    item_ch.valid    <= 1'b0;
    item_ch.mode     <= ModeAdd;
    item_ch.item_key <= '0;
    item_ch.amount   <= '0;
    for (int r = 0; r < MaxRows; r++) begin
      coef_mult[r]   = MultReset[r];
      coef_offset[r] = OffsetReset[r];
    end
    for (int r = 0; r < Rows; r++)
      for (int c = 0; c < Columns; c++)
        tally[r][c] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_saturation();
    test_coef_extremes();
    test_random_traffic(110, 1'b0, 0, 1);
    test_random_traffic(110, 1'b1, 1, 8);
    test_random_traffic(110, 1'b0, 2, 90);
    test_random_traffic(110, 1'b1, 2, 4);
    test_random_traffic(110, 1'b1, 1, 40);

    if (estimate_queue.size() != 0)
      report_mismatch($sformatf("%0d queries left without an estimate",
                                estimate_queue.size()));
    if (mismatch_count == 0) begin
      $display("count_min_sketch regression: pass");
    end else begin
      $display("count_min_sketch regression: fail");
    end
    $finish;
  end

endmodule
